// ===== hdl/ula_pkg.sv =====
// Shared types and constants for the UART line assembler.
// No dependencies.
package ula_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int ADDR_W = $clog2(BUF_DEPTH);
  localparam logic [7:0] DEPTH_LIM = 8'(BUF_DEPTH);

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } ula_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic       rx_fault;
    logic [5:0] read_index;
  } ula_in_t;

  typedef struct packed {
    logic       line_done;
    logic [6:0] line_length;
    logic       armed;
    logic [7:0] fault_count;
    logic       event_flag;
    logic [7:0] read_data;
  } ula_out_t;

endpackage

// ===== hdl/ula_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ula_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/uart_line_assembler_unit.sv =====
// UART receive line assembler: gathers bytes into a CR-terminated line buffer.
// Depends on ula_pkg and ula_ram.
// Result path: stage one registers the accepted word and the line RAM read, then the output register.
// Throughput: one word per cycle; input stalls only while the output register is stalled.
// Control state updates at accept; buffer reads and writes use the single line RAM.
// Reset: length 0, armed, fault count 0, event clear; buffer contents undefined.
module uart_line_assembler_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ula_pkg::ula_in_t  in_word,
  output logic           out_valid,
  input  logic           out_stall,
  output ula_pkg::ula_out_t out_word
);
  import ula_pkg::*;

  logic [6:0] fill_r, fill_nxt;
  logic       acc_r, acc_nxt;
  logic [7:0] tally_r, tally_nxt;
  logic       event_r, event_nxt;
  logic       done;
  logic       ram_we;
  logic [7:0] ram_wdata;
  logic [7:0] ram_rdata;
  logic       rd_ok;
  ula_cmd_t   cmd;

  logic       s1_valid_r;
  ula_out_t   s1_word_r;
  logic       s1_rd_r;
  logic       out_valid_r;
  ula_out_t   out_word_r;
  logic       out_load;
  logic       in_acc;

  assign cmd      = ula_cmd_t'(in_word.cmd);
  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;
  assign rd_ok    = ({2'b00, in_word.read_index} < DEPTH_LIM);

  always_comb begin
    fill_nxt  = fill_r;
    acc_nxt   = acc_r;
    tally_nxt = tally_r;
    event_nxt = event_r;
    done      = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = in_word.rx_byte;
    unique case (cmd)
      CMD_BYTE: begin
        if (!in_word.rx_fault && in_word.rx_byte != CH_LF) begin
          if (acc_r && tally_r == 8'd0 && {1'b0, fill_r} < DEPTH_LIM) begin
            ram_we = 1'b1;
            if (in_word.rx_byte == CH_CR) begin
              ram_wdata = 8'd0;
              acc_nxt   = 1'b0;
              done      = 1'b1;
              event_nxt = 1'b1;
            end else begin
              fill_nxt = fill_r + 7'd1;
            end
          end else begin
            fill_nxt = 7'd0;
            if (in_word.rx_byte == CH_CR) begin
              tally_nxt = 8'd0;
              acc_nxt   = 1'b1;
            end else begin
              tally_nxt = tally_r + 8'd1;
            end
          end
        end
      end
      CMD_RELEASE: begin
        fill_nxt = 7'd0;
        acc_nxt  = 1'b1;
      end
      CMD_READ: begin
      end
      CMD_CLEAR: begin
        event_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  ula_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (in_acc && ram_we),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (in_acc && cmd == CMD_READ),
    .raddr (ADDR_W'(in_word.read_index)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 7'd0;
      acc_r       <= 1'b1;
      tally_r     <= 8'd0;
      event_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        fill_r  <= fill_nxt;
        acc_r   <= acc_nxt;
        tally_r <= tally_nxt;
        event_r <= event_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r.line_done   <= done;
      s1_word_r.line_length <= fill_nxt;
      s1_word_r.armed       <= acc_nxt;
      s1_word_r.fault_count <= tally_nxt;
      s1_word_r.event_flag  <= event_nxt;
      s1_word_r.read_data   <= 8'd0;
      s1_rd_r               <= (cmd == CMD_READ) && rd_ok;
    end
    if (out_load) begin
      out_word_r.line_done   <= s1_word_r.line_done;
      out_word_r.line_length <= s1_word_r.line_length;
      out_word_r.armed       <= s1_word_r.armed;
      out_word_r.fault_count <= s1_word_r.fault_count;
      out_word_r.event_flag  <= s1_word_r.event_flag;
      out_word_r.read_data   <= s1_rd_r ? ram_rdata : s1_word_r.read_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stall without a blocked pipeline");

  a_fill_lim: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, fill_r} <= DEPTH_LIM)
    else $error("fill count beyond buffer depth");

  a_done_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.line_done) |-> (!out_word_r.armed && out_word_r.event_flag))
    else $error("completed line left receiver armed or event clear");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !s1_rd_r) |=> (out_word_r.read_data == 8'd0))
    else $error("read data nonzero for a non-read word");

  a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !in_acc && out_load) |=> !s1_valid_r)
    else $error("stage one not drained");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for uart_line_assembler_unit: directed line, fault, overflow
// and error-count cases, then random command words and a long receiver hold-off, all checked against a local predictor.
// Depends on ula_pkg and the line assembler RTL.
module tb_top;
  import ula_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ula_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  ula_out_t out_word;

  // predicted line buffer state
  logic [7:0] line_mem [BUF_DEPTH];
  bit         store_written [BUF_DEPTH];
  logic [6:0] line_fill;
  logic       line_armed;
  logic [7:0] err_tally;
  logic       line_evt;

  ula_out_t result_q[$];
  int       mismatches;
  int       words_sent;
  int       cycle_count;
  int       tx_idle_pct;
  int       rx_idle_pct;
  bit       hold_pending;

  uart_line_assembler_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ula_out_t predict_line_result(ula_in_t w);
    ula_out_t r;
    r = '0;
    case (ula_cmd_t'(w.cmd))
      CMD_BYTE: begin
        if (!w.rx_fault && w.rx_byte != CH_LF) begin
          if (line_armed && err_tally == 8'd0 && int'(line_fill) < BUF_DEPTH) begin
            store_written[line_fill[5:0]] = 1'b1;
            if (w.rx_byte == CH_CR) begin
              line_mem[line_fill[5:0]] = 8'h00;
              line_armed = 1'b0;
              line_evt = 1'b1;
              r.line_done = 1'b1;
            end else begin
              line_mem[line_fill[5:0]] = w.rx_byte;
              line_fill = line_fill + 7'd1;
            end
          end else begin
            err_tally = err_tally + 8'd1;
            line_fill = '0;
            if (w.rx_byte == CH_CR) begin
              err_tally = '0;
              line_armed = 1'b1;
            end
          end
        end
      end
      CMD_RELEASE: begin
        line_fill = '0;
        line_armed = 1'b1;
      end
      CMD_READ: begin
        r.read_data = line_mem[w.read_index];
      end
      default: begin
        line_evt = 1'b0;
      end
    endcase
    r.line_length = line_fill;
    r.armed = line_armed;
    r.fault_count = err_tally;
    r.event_flag = line_evt;
    return r;
  endfunction

  // predict on input accept, compare on output accept
  always @(posedge clk) begin : result_check
    ula_out_t exp_w;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        result_q.push_back(predict_line_result(in_word));
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result word %h", out_word);
          end
        end else begin
          exp_w = result_q.pop_front();
          if (out_word.line_done !== exp_w.line_done ||
              out_word.line_length !== exp_w.line_length ||
              out_word.armed !== exp_w.armed ||
              out_word.fault_count !== exp_w.fault_count ||
              out_word.event_flag !== exp_w.event_flag ||
              out_word.read_data !== exp_w.read_data) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp done=%0d len=%0d armed=%0d faults=%0d evt=%0d data=%h",
                       exp_w.line_done, exp_w.line_length, exp_w.armed,
                       exp_w.fault_count, exp_w.event_flag, exp_w.read_data);
              $display("          got done=%0d len=%0d armed=%0d faults=%0d evt=%0d data=%h",
                       out_word.line_done, out_word.line_length, out_word.armed,
                       out_word.fault_count, out_word.event_flag, out_word.read_data);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall, with an optional long hold-off
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_pending = 1'b0;
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_word(ula_in_t w);
    if (ula_cmd_t'(w.cmd) == CMD_READ && !store_written[w.read_index]) begin
      w.cmd = CMD_CLEAR;
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_cmd(ula_cmd_t c, logic [7:0] b, logic f, logic [5:0] idx);
    ula_in_t w;
    w.cmd = c;
    w.rx_byte = b;
    w.rx_fault = f;
    w.read_index = idx;
    send_word(w);
  endtask

  task automatic send_byte(logic [7:0] b, logic f);
    send_cmd(CMD_BYTE, b, f, 6'($urandom));
  endtask

  task automatic send_read(logic [5:0] idx);
    send_cmd(CMD_READ, 8'($urandom), 1'($urandom), idx);
  endtask

  task automatic send_ctrl(ula_cmd_t c);
    send_cmd(c, 8'($urandom), 1'($urandom), 6'($urandom));
  endtask

  task automatic send_noise();
    ula_in_t w;
    w.cmd = 2'($urandom_range(3));
    w.rx_byte = 8'($urandom);
    w.rx_fault = 1'($urandom_range(1));
    w.read_index = 6'($urandom);
    send_word(w);
  endtask

  function automatic logic [7:0] rand_text();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CH_CR || b == CH_LF) begin
      b = 8'h41;
    end
    return b;
  endfunction

  // full buffer, then one more byte; leaves every entry written
  task automatic test_overflow();
    int i;
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    for (i = 2; i < BUF_DEPTH; i++) begin
      send_byte(rand_text(), 1'b0);
    end
    send_byte(8'h5a, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_read(6'd0);
    send_read(6'd1);
    send_read(6'd63);
    send_read(6'h2a);
    send_read(6'h15);
  endtask

  task automatic test_basic_line();
    send_byte(8'h48, 1'b0);
    send_byte(8'h69, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_read(6'd0);
    send_read(6'd1);
    send_read(6'd2);
    send_ctrl(CMD_CLEAR);
    send_ctrl(CMD_RELEASE);
  endtask

  task automatic test_fault_drop();
    send_byte(8'h58, 1'b1);
    send_byte(CH_CR, 1'b1);
    send_byte(CH_LF, 1'b1);
    send_byte(8'h59, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_read(6'd0);
  endtask

  // bytes while a line is held go to the error path; CR recovers
  task automatic test_held_line();
    send_byte(8'h5a, 1'b0);
    send_byte(8'h51, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_ctrl(CMD_CLEAR);
  endtask

  // error count wraps from 255 to 0, so the receiver takes bytes again
  task automatic test_tally_wrap();
    int i;
    send_byte(8'h41, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(8'h42, 1'b0);
    send_ctrl(CMD_RELEASE);
    for (i = 0; i < 255; i++) begin
      send_byte(rand_text(), 1'b0);
    end
    send_byte(8'h43, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_read(6'd0);
    send_ctrl(CMD_CLEAR);
    send_ctrl(CMD_RELEASE);
  endtask

  task automatic send_line();
    int len;
    int sel;
    int i;
    sel = $urandom_range(99);
    if (sel < 85) begin
      len = $urandom_range(8);
    end else if (sel < 95) begin
      len = $urandom_range(63, 9);
    end else begin
      len = $urandom_range(66, 64);
    end
    if ($urandom_range(9) != 0) begin
      send_ctrl(CMD_RELEASE);
    end
    for (i = 0; i < len; i++) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        send_byte(8'($urandom), 1'b1);
      end else if (sel < 7) begin
        send_byte(CH_LF, 1'b0);
      end else begin
        send_byte(rand_text(), 1'b0);
      end
    end
    send_byte(CH_CR, 1'b0);
    repeat ($urandom_range(3)) send_read(6'($urandom_range(len)));
    if ($urandom_range(1) != 0) begin
      send_ctrl(CMD_CLEAR);
    end
  endtask

  task automatic test_random(int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(99) < 75) begin
        send_line();
      end else begin
        repeat ($urandom_range(6, 1)) send_noise();
      end
    end
  endtask

  task automatic test_backpressure();
    hold_pending = 1'b1;
    repeat (40) send_noise();
    send_line();
  endtask

  initial begin
    line_fill = '0;
    line_armed = 1'b1;
    err_tally = '0;
    line_evt = 1'b0;
    mismatches = 0;
    words_sent = 0;
    cycle_count = 0;
    hold_pending = 1'b0;
    tx_idle_pct = 6;
    rx_idle_pct = 58;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_overflow();
    test_basic_line();
    test_fault_drop();
    test_held_line();
    test_tally_wrap();
    test_random(500);
    tx_idle_pct = 58;
    rx_idle_pct = 6;
    test_random(500);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random(500);

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
